/* hdl/wave_equation_stencil_step_defines.svh */
// assertion macros for the wave stencil block
`ifndef WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH
`define WAVE_EQUATION_STENCIL_STEP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define WES_ASSERT_IMPL(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |-> (rhs)) \
        else $error("assertion failed");

// next-cycle implication
`define WES_ASSERT_NEXT(label, clk, rstn, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rstn) (lhs) |=> (rhs)) \
        else $error("assertion failed");

`endif

/* hdl/wes_pkg.sv */
`default_nettype none
package wes_pkg;
    localparam int MaxNodes = 1024;
    localparam int IdxW = $clog2(MaxNodes);
    localparam int CntW = IdxW + 1;
    localparam int ValW = 32;
    localparam int CoefW = 18;

    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_STEP = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [1:0] SCH_A = 2'd0;
    localparam logic [1:0] SCH_B = 2'd1;
    localparam logic [1:0] SCH_C = 2'd2;

    localparam logic [1:0] BND_FIXED = 2'd0;
    localparam logic [1:0] BND_FREE = 2'd1;
    localparam logic [1:0] BND_OUT = 2'd2;
    localparam logic [1:0] BND_DRIVE = 2'd3;

    localparam logic [2:0] REG_SCHEME = 3'd0;
    localparam logic [2:0] REG_LEFT = 3'd1;
    localparam logic [2:0] REG_RIGHT = 3'd2;
    localparam logic [2:0] REG_LCOUR = 3'd3;
    localparam logic [2:0] REG_RCOUR = 3'd4;
    localparam logic [2:0] REG_COUNT = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] node_index;
        logic [17:0] coefficient;
        logic signed [31:0] drive;
    } in_word_t;

    typedef struct packed {
        logic is_energy;
        logic signed [31:0] node_value;
        logic [62:0] energy;
    } out_word_t;

    // saturate a wide signed sum to value width
    function automatic logic signed [ValW-1:0] sat_val(input logic signed [ValW+3:0] v);
        logic signed [ValW+3:0] hi;
        logic signed [ValW+3:0] lo;
        hi = (ValW+4)'((64'sd1 <<< (ValW - 1)) - 64'sd1);
        lo = -hi - (ValW+4)'(1);
        if (v > hi) return hi[ValW-1:0];
        if (v < lo) return lo[ValW-1:0];
        return v[ValW-1:0];
    endfunction
endpackage
`default_nettype wire

/* hdl/wes_ram.sv */
`default_nettype none
module wes_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input wire logic aclk,
    input wire logic we,
    input wire logic [$clog2(Depth)-1:0] waddr,
    input wire logic [Width-1:0] wdata,
    input wire logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0] rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/wes_mac.sv */
`default_nettype none
module wes_mac
    import wes_pkg::*;
(
    input wire logic aclk,
    input wire logic [CoefW:0] coef,
    input wire logic signed [ValW+2:0] data,
    input wire logic half,
    output logic signed [ValW+19:0] prod_reg
);
    // rounded coef*data >> 16 (or 17 when half), ties up
    logic signed [ValW+21:0] full;
    logic signed [ValW+21:0] rnd;

    always_comb begin
        full = $signed({1'b0, coef}) * data;
        if (half) begin
            rnd = (full + (ValW+22)'(65536)) >>> 17;
        end else begin
            rnd = (full + (ValW+22)'(32768)) >>> 16;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= rnd[ValW+19:0];
    end
endmodule
`default_nettype wire

/* hdl/wave_equation_stencil_step.sv */
// wave equation stencil step
// input channel s_valid/s_ready carries one word: load, step or read.
// result channel m_valid/m_ready carries one word per step or read, none per load.
// apb port writes scheme, boundaries, courant factors and node count.
// one shared multiplier under a sequencer does every coefficient product.
// a load is written when taken; a read result is registered in s_read2, after s_read1.
// a step walks the nodes in use: memory reads and multiplier passes per interior node
// (more passes for schemes b and c), then each end, then a pass per node to commit
// and sum squares.
// after reset a clearing pass zeroes the current, previous and coefficient memories;
// s_ready stays low meanwhile, apb writes are taken.
// a result sits in the output register until m_ready; the block takes
// no new word until it is delivered.
`default_nettype none
module wave_equation_stencil_step
    import wes_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    output logic s_ready,
    input wire in_word_t s_data,
    output logic m_valid,
    input wire logic m_ready,
    output out_word_t m_data,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [4:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ1, S_READ2,
        S_I_RD, S_I_W0, S_I_W1, S_I_W2, S_I_M0, S_I_M1, S_I_M2, S_I_SUM,
        S_L_RD, S_L_W, S_L_M, S_L_DO, S_R_RD, S_R_W, S_R_M, S_R_DO,
        S_C_RD, S_C_W, S_C_DO, S_OUT
    } state_t;

    state_t state_reg;
    logic [1:0] scheme_reg, lb_reg, rb_reg;
    logic [17:0] lc_reg, rc_reg;
    logic [10:0] cnt_reg;
    in_word_t in_reg;
    out_word_t out_reg;
    logic [CntW-1:0] i_reg, n_reg;
    logic signed [ValW-1:0] fm_reg, f0_reg, fp_reg, p0_reg;
    logic [CoefW-1:0] cm_reg, c0_reg, cp_reg;
    logic signed [ValW+19:0] acc_reg;
    logic signed [ValW-1:0] nx1_reg, nxl_reg;
    logic [62:0] sum_reg;
    logic [1:0] wait_reg;

    // memories: current, previous, coefficient, next
    logic cur_we, prv_we, cof_we, nxt_we;
    logic [IdxW-1:0] cur_wa, prv_wa, cof_wa, nxt_wa, cur_ra, prv_ra, cof_ra, nxt_ra;
    logic [ValW-1:0] cur_wd, prv_wd, nxt_wd, cur_rd, prv_rd, nxt_rd;
    logic [CoefW-1:0] cof_wd, cof_rd;

    wes_ram #(.Width(ValW), .Depth(MaxNodes)) u_cur (.aclk, .we(cur_we), .waddr(cur_wa),
        .wdata(cur_wd), .raddr(cur_ra), .rdata(cur_rd));
    wes_ram #(.Width(ValW), .Depth(MaxNodes)) u_prv (.aclk, .we(prv_we), .waddr(prv_wa),
        .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd));
    wes_ram #(.Width(CoefW), .Depth(MaxNodes)) u_cof (.aclk, .we(cof_we), .waddr(cof_wa),
        .wdata(cof_wd), .raddr(cof_ra), .rdata(cof_rd));

    // shared multiplier
    logic [CoefW:0] mc;
    logic signed [ValW+2:0] md;
    logic mhalf;
    logic signed [ValW+19:0] mprod;
    wes_mac u_mac (.aclk, .coef(mc), .data(md), .half(mhalf), .prod_reg(mprod));

    logic signed [ValW+2:0] fm_x, f0_x, fp_x;
    logic signed [ValW+3:0] base_x, nv_x;
    logic signed [ValW-1:0] nv;
    logic [IdxW-1:0] i_ix, ip_ix, im_ix;
    logic [CntW-1:0] n_clamp;
    logic [63:0] sq;
    logic [63:0] sum_x;
    logic signed [ValW:0] vabs;
    logic wr_en;
    logic [2:0] preg;

    assign i_ix = i_reg[IdxW-1:0];
    assign ip_ix = i_ix + IdxW'(1);
    assign im_ix = i_ix - IdxW'(1);
    assign fm_x = (ValW+3)'(fm_reg);
    assign f0_x = (ValW+3)'(f0_reg);
    assign fp_x = (ValW+3)'(fp_reg);
    assign base_x = (ValW+4)'(f0_reg) * 2 - (ValW+4)'(p0_reg);
    assign nv_x = (ValW+4)'(acc_reg) + base_x;
    assign nv = sat_val(nv_x);
    assign wr_en = psel && penable && pwrite;
    assign preg = paddr[4:2];
    assign pready = 1'b1;

    always_comb begin
        n_clamp = CntW'(MaxNodes);
        if (cnt_reg < 11'd3) n_clamp = CntW'(3);
        else if (32'(cnt_reg) < MaxNodes) n_clamp = CntW'(cnt_reg);
    end

    always_comb begin
        case (preg)
            REG_SCHEME: prdata = {30'd0, scheme_reg};
            REG_LEFT: prdata = {30'd0, lb_reg};
            REG_RIGHT: prdata = {30'd0, rb_reg};
            REG_LCOUR: prdata = {14'd0, lc_reg};
            REG_RCOUR: prdata = {14'd0, rc_reg};
            REG_COUNT: prdata = {21'd0, cnt_reg};
            default: prdata = '0;
        endcase
    end

    // multiplier operand select
    always_comb begin
        mc = '0;
        md = '0;
        mhalf = 1'b0;
        case (state_reg)
            S_I_M0: begin
                if (scheme_reg == SCH_B) begin
                    mc = (CoefW+1)'(c0_reg) + (CoefW+1)'(cp_reg);
                    md = fp_x - f0_x;
                    mhalf = 1'b1;
                end else if (scheme_reg == SCH_C) begin
                    mc = (CoefW+1)'(cp_reg);
                    md = fp_x;
                end else begin
                    mc = (CoefW+1)'(c0_reg);
                    md = fp_x + fm_x - f0_x - f0_x;
                end
            end
            S_I_M1: begin
                if (scheme_reg == SCH_B) begin
                    mc = (CoefW+1)'(c0_reg) + (CoefW+1)'(cm_reg);
                    md = f0_x - fm_x;
                    mhalf = 1'b1;
                end else begin
                    mc = (CoefW+1)'(c0_reg);
                    md = f0_x;
                end
            end
            S_I_M2: begin
                mc = (CoefW+1)'(cm_reg);
                md = fm_x;
            end
            S_L_M, S_L_DO: begin
                mc = (CoefW+1)'(lc_reg);
                md = fp_x - f0_x;
            end
            S_R_M, S_R_DO: begin
                mc = (CoefW+1)'(rc_reg);
                md = fm_x - f0_x;
            end
            default: ;
        endcase
    end

    // memory port control
    always_comb begin
        cur_we = 1'b0; prv_we = 1'b0; cof_we = 1'b0; nxt_we = 1'b0;
        cur_wa = i_ix; prv_wa = i_ix; cof_wa = i_ix; nxt_wa = i_ix;
        cur_wd = '0; prv_wd = '0; cof_wd = '0; nxt_wd = nv;
        cur_ra = i_ix; prv_ra = i_ix; cof_ra = i_ix; nxt_ra = i_ix;
        case (state_reg)
            S_CLEAR: begin
                cur_we = 1'b1; prv_we = 1'b1; cof_we = 1'b1;
            end
            S_IDLE: begin
                cof_we = s_valid && s_data.kind == KIND_LOAD;
                cof_wa = s_data.node_index;
                cof_wd = s_data.coefficient;
                cur_ra = s_data.node_index;
            end
            S_READ1: cur_ra = in_reg.node_index;
            S_I_W0: begin
                cur_ra = im_ix; cof_ra = im_ix;
            end
            S_I_W1, S_I_W2: begin
                cur_ra = ip_ix; cof_ra = ip_ix;
            end
            S_I_SUM: nxt_we = 1'b1;
            S_L_W: cur_ra = IdxW'(1);
            S_R_W: cur_ra = IdxW'(n_reg - CntW'(2));
            S_C_RD: nxt_ra = i_ix;
            S_C_DO: begin
                prv_we = 1'b1; prv_wd = cur_rd;
                cur_we = 1'b1; cur_wd = nxt_rd;
            end
            default: ;
        endcase
    end

    always_comb begin
        vabs = nxt_rd[ValW-1] ? -(ValW+1)'($signed(nxt_rd)) : (ValW+1)'($signed(nxt_rd));
        sq = 64'(vabs) * 64'(vabs);
        sum_x = 64'(sum_reg) + sq;
        if (sum_x[63]) sum_x = 64'h7FFF_FFFF_FFFF_FFFF;
    end

    // boundary value for an end node
    function automatic logic signed [ValW-1:0] bnd(input logic [1:0] code,
        input logic signed [ValW-1:0] inner_next, input logic signed [ValW-1:0] edge_v,
        input logic signed [ValW+19:0] prod, input logic signed [ValW-1:0] drv);
        case (code)
            BND_FREE: return inner_next;
            BND_OUT: return sat_val((ValW+4)'(edge_v) + (ValW+4)'(prod));
            BND_DRIVE: return drv;
            default: return '0;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            i_reg <= '0;
            wait_reg <= '0;
            scheme_reg <= '0; lb_reg <= '0; rb_reg <= '0;
            lc_reg <= '0; rc_reg <= '0; cnt_reg <= 11'(MaxNodes);
            m_valid <= 1'b0;
            s_ready <= 1'b0;
        end else begin
            if (wr_en) begin
                case (preg)
                    REG_SCHEME: scheme_reg <= pwdata[1:0];
                    REG_LEFT: lb_reg <= pwdata[1:0];
                    REG_RIGHT: rb_reg <= pwdata[1:0];
                    REG_LCOUR: lc_reg <= pwdata[17:0];
                    REG_RCOUR: rc_reg <= pwdata[17:0];
                    REG_COUNT: cnt_reg <= pwdata[10:0];
                    default: ;
                endcase
            end
            case (state_reg)
                S_CLEAR: begin
                    i_reg <= i_reg + CntW'(1);
                    if (i_reg == CntW'(MaxNodes - 1)) begin
                        state_reg <= S_IDLE;
                        s_ready <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg <= s_data;
                        case (s_data.kind)
                            KIND_STEP: begin
                                s_ready <= 1'b0;
                                n_reg <= n_clamp;
                                i_reg <= CntW'(1);
                                sum_reg <= '0;
                                state_reg <= S_I_RD;
                            end
                            KIND_READ: begin
                                s_ready <= 1'b0;
                                state_reg <= S_READ1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_READ1: state_reg <= S_READ2;
                S_READ2: begin
                    out_reg.is_energy <= 1'b0;
                    out_reg.node_value <= cur_rd;
                    out_reg.energy <= '0;
                    m_valid <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_I_RD: state_reg <= S_I_W0;
                S_I_W0: begin
                    f0_reg <= cur_rd; c0_reg <= cof_rd; p0_reg <= prv_rd;
                    state_reg <= S_I_W1;
                end
                S_I_W1: begin
                    fm_reg <= cur_rd; cm_reg <= cof_rd;
                    state_reg <= S_I_W2;
                end
                S_I_W2: begin
                    state_reg <= S_I_M0;
                end
                S_I_M0: begin
                    if (wait_reg == 2'd0) begin
                        fp_reg <= cur_rd; cp_reg <= cof_rd;
                        wait_reg <= 2'd1;
                    end else begin
                        wait_reg <= 2'd0;
                        state_reg <= S_I_M1;
                    end
                end
                S_I_M1: begin
                    acc_reg <= mprod;
                    state_reg <= (scheme_reg == SCH_B || scheme_reg == SCH_C) ? S_I_M2
                                                                               : S_I_SUM;
                end
                S_I_M2: begin
                    if (scheme_reg == SCH_B) acc_reg <= acc_reg - mprod;
                    else acc_reg <= acc_reg - mprod - mprod;
                    state_reg <= (scheme_reg == SCH_C) ? S_I_SUM : S_I_SUM;
                    if (scheme_reg == SCH_C) wait_reg <= 2'd1;
                end
                S_I_SUM: begin
                    if (wait_reg == 2'd1) begin
                        acc_reg <= acc_reg + mprod;
                        wait_reg <= 2'd0;
                    end else begin
                        if (i_reg == CntW'(1)) nx1_reg <= nv;
                        nxl_reg <= nv;
                        if (i_reg + CntW'(2) >= n_reg) begin
                            i_reg <= '0;
                            state_reg <= S_L_RD;
                        end else begin
                            i_reg <= i_reg + CntW'(1);
                            state_reg <= S_I_RD;
                        end
                    end
                end
                S_L_RD: state_reg <= S_L_W;
                S_L_W: begin
                    f0_reg <= cur_rd;
                    state_reg <= S_L_M;
                end
                S_L_M: begin
                    fp_reg <= cur_rd;
                    state_reg <= S_L_DO;
                    wait_reg <= 2'd1;
                end
                S_L_DO: begin
                    if (wait_reg == 2'd1) wait_reg <= 2'd0;
                    else begin
                        i_reg <= n_reg - CntW'(1);
                        state_reg <= S_R_RD;
                    end
                end
                S_R_RD: state_reg <= S_R_W;
                S_R_W: begin
                    f0_reg <= cur_rd;
                    state_reg <= S_R_M;
                end
                S_R_M: begin
                    fm_reg <= cur_rd;
                    state_reg <= S_R_DO;
                    wait_reg <= 2'd1;
                end
                S_R_DO: begin
                    if (wait_reg == 2'd1) wait_reg <= 2'd0;
                    else begin
                        i_reg <= '0;
                        state_reg <= S_C_RD;
                    end
                end
                S_C_RD: state_reg <= S_C_W;
                S_C_W: state_reg <= S_C_DO;
                S_C_DO: begin
                    sum_reg <= sum_x[62:0];
                    if (i_reg + CntW'(1) >= n_reg) begin
                        out_reg.is_energy <= 1'b1;
                        out_reg.node_value <= '0;
                        out_reg.energy <= sum_x[62:0];
                        m_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        i_reg <= i_reg + CntW'(1);
                        state_reg <= S_C_RD;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        s_ready <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // end-node writes into the next-value store
    logic end_we;
    logic signed [ValW-1:0] end_val;
    always_comb begin
        end_we = 1'b0;
        end_val = '0;
        if (state_reg == S_L_DO && wait_reg == 2'd0) begin
            end_we = 1'b1;
            end_val = bnd(lb_reg, nx1_reg, f0_reg, mprod, in_reg.drive);
        end else if (state_reg == S_R_DO && wait_reg == 2'd0) begin
            end_we = 1'b1;
            end_val = bnd(rb_reg, nxl_reg, f0_reg, mprod, in_reg.drive);
        end
    end

    logic signed [ValW-1:0] endw_reg;
    logic endv_reg;
    logic [IdxW-1:0] enda_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            endv_reg <= 1'b0;
        end else begin
            endv_reg <= end_we;
        end
        endw_reg <= end_val;
        enda_reg <= i_ix;
    end

    // fold end writes into the next store during the following read state
    logic nxt_we_f;
    logic [IdxW-1:0] nxt_wa_f;
    logic [ValW-1:0] nxt_wd_f;
    assign nxt_we_f = nxt_we || endv_reg;
    assign nxt_wa_f = endv_reg ? enda_reg : nxt_wa;
    assign nxt_wd_f = endv_reg ? endw_reg : nxt_wd;

    wes_ram #(.Width(ValW), .Depth(MaxNodes)) u_nxt (.aclk, .we(nxt_we_f),
        .waddr(nxt_wa_f), .wdata(nxt_wd_f), .raddr(nxt_ra), .rdata(nxt_rd));

    assign m_data = out_reg;
endmodule
`default_nettype wire

/* hdl/wes_checker.sv */
`default_nettype none
`include "wave_equation_stencil_step_defines.svh"
module wes_checker
    import wes_pkg::*;
(
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire out_word_t m_data
);
    `WES_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `WES_ASSERT_IMPL(a_busy, aclk, aresetn, m_valid, !s_ready)
    `WES_ASSERT_IMPL(a_read_no_energy, aclk, aresetn, m_valid && !m_data.is_energy, m_data.energy == '0)
    `WES_ASSERT_IMPL(a_energy_no_val, aclk, aresetn, m_valid && m_data.is_energy, m_data.node_value == '0)
endmodule

bind wave_equation_stencil_step wes_checker u_chk (.aclk, .aresetn, .s_ready,
    .m_valid, .m_ready, .m_data);
`default_nettype wire

/* bench/tb_wave_equation_stencil_step.sv */
`timescale 1ns / 1ps
module tb_wave_equation_stencil_step;
    import wes_pkg::*;

    localparam int RunLimit = 3000000;
    localparam longint unsigned EnergyMax = 64'h7FFF_FFFF_FFFF_FFFF;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_word_t s_data;
    logic m_valid;
    logic m_ready;
    out_word_t m_data;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    wave_equation_stencil_step dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // model of the grid
    longint disp_now [MaxNodes];
    longint disp_old [MaxNodes];
    longint disp_next [MaxNodes];
    longint node_coef [MaxNodes];
    logic [1:0] cfg_scheme;
    logic [1:0] cfg_left;
    logic [1:0] cfg_right;
    longint cfg_lcour;
    longint cfg_rcour;
    int cfg_count;

    out_word_t pending_results [$];
    int error_count;
    int cycle_count;
    bit calm;
    bit hold_go;
    int hold_left;

    typedef struct {
        bit is_cfg;
        in_word_t word;
        bit typed;
        out_word_t result;
        logic [2:0] reg_idx;
        logic [31:0] reg_val;
    } stim_row_t;

    stim_row_t stim_table [$];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sat_disp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // c*d / 2^sh rounded, ties upward
    function automatic longint scaled_product(longint c, longint d, int sh);
        longint q;
        longint r;
        longint frac;
        q = d >>> sh;
        r = d - (q <<< sh);
        frac = (c * r + (64'sd1 <<< (sh - 1))) >>> sh;
        return c * q + frac;
    endfunction

    function automatic int active_nodes();
        int n;
        n = cfg_count;
        if (n < 3) n = 3;
        if (n > MaxNodes) n = MaxNodes;
        return n;
    endfunction

    function automatic longint end_value(logic [1:0] code, longint cour, longint edge_v,
                                         longint inner, longint inner_next, longint drv);
        case (code)
            BND_FREE: return inner_next;
            BND_OUT: return sat_disp(edge_v + scaled_product(cour, inner - edge_v, 16));
            BND_DRIVE: return sat_disp(drv);
            default: return 0;
        endcase
    endfunction

    function automatic longint unsigned advance_grid(longint drv);
        int n;
        longint acc;
        longint a;
        longint unsigned sq;
        longint unsigned sum;
        n = active_nodes();
        for (int i = 1; i + 1 < n; i++) begin
            if (cfg_scheme == SCH_B) begin
                acc = scaled_product(node_coef[i] + node_coef[i+1],
                                     disp_now[i+1] - disp_now[i], 17)
                    - scaled_product(node_coef[i] + node_coef[i-1],
                                     disp_now[i] - disp_now[i-1], 17);
            end else if (cfg_scheme == SCH_C) begin
                acc = scaled_product(node_coef[i+1], disp_now[i+1], 16)
                    - 2 * scaled_product(node_coef[i], disp_now[i], 16)
                    + scaled_product(node_coef[i-1], disp_now[i-1], 16);
            end else begin
                acc = scaled_product(node_coef[i],
                                     disp_now[i+1] + disp_now[i-1] - 2 * disp_now[i], 16);
            end
            disp_next[i] = sat_disp(2 * disp_now[i] - disp_old[i] + acc);
        end
        disp_next[0] = end_value(cfg_left, cfg_lcour, disp_now[0], disp_now[1],
                                 disp_next[1], drv);
        disp_next[n-1] = end_value(cfg_right, cfg_rcour, disp_now[n-1], disp_now[n-2],
                                   disp_next[n-2], drv);
        sum = 0;
        for (int i = 0; i < n; i++) begin
            disp_old[i] = disp_now[i];
            disp_now[i] = disp_next[i];
            a = disp_next[i] < 0 ? -disp_next[i] : disp_next[i];
            sq = (a > 64'sd3037000499) ? EnergyMax : longint'(a * a);
            sum = (sq > EnergyMax - sum) ? EnergyMax : sum + sq;
        end
        return sum;
    endfunction

    // updates the model, returns 1 when the word yields a result
    function automatic bit apply_word(in_word_t w, output out_word_t res);
        res = '0;
        case (w.kind)
            KIND_LOAD: begin
                node_coef[w.node_index] = w.coefficient;
                return 1'b0;
            end
            KIND_STEP: begin
                res.is_energy = 1'b1;
                res.energy = 63'(advance_grid(longint'(w.drive)));
                return 1'b1;
            end
            KIND_READ: begin
                res.node_value = 32'(sat_disp(disp_now[w.node_index]));
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic void set_register(logic [2:0] idx, logic [31:0] v);
        case (idx)
            REG_SCHEME: cfg_scheme = v[1:0];
            REG_LEFT: cfg_left = v[1:0];
            REG_RIGHT: cfg_right = v[1:0];
            REG_LCOUR: cfg_lcour = v[17:0];
            REG_RCOUR: cfg_rcour = v[17:0];
            REG_COUNT: cfg_count = v[10:0];
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        error_count++;
    endtask

    task automatic send_word(in_word_t w, bit typed, out_word_t typed_res);
        out_word_t res;
        bit has_res;
        @(negedge aclk);
        if (!calm) begin
            while ($urandom_range(0, 99) < 22) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= w;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        has_res = apply_word(w, res);
        if (has_res) pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] v);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(4 * idx);
        pwdata <= v;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        set_register(idx, v);
    endtask

    function automatic in_word_t random_word();
        in_word_t w;
        int pick;
        int n;
        n = active_nodes();
        w.kind = KIND_LOAD;
        w.node_index = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, n - 1));
        pick = $urandom_range(0, 9);
        w.coefficient = pick == 0 ? 18'($urandom) : pick == 1 ? 18'd131072
                      : 18'($urandom_range(0, 65536));
        pick = $urandom_range(0, 9);
        w.drive = pick == 0 ? 32'($urandom) : pick == 1 ? 32'h7FFF_FFFF
                : pick == 2 ? 32'h8000_0000 : 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        pick = $urandom_range(0, 99);
        if (pick < 28) w.kind = KIND_LOAD;
        else if (pick < 65) w.kind = KIND_STEP;
        else if (pick < 96) w.kind = KIND_READ;
        else w.kind = 2'd3;
        if (w.kind == KIND_STEP && n > 64 && $urandom_range(0, 9) != 0) w.kind = KIND_READ;
        return w;
    endfunction

    function automatic logic [31:0] courant_value();
        int pick;
        pick = $urandom_range(0, 5);
        if (pick == 0) return 32'd0;
        if (pick == 1) return 32'd131072;
        if (pick == 2) return 32'h3FFFF;
        return 32'($urandom_range(0, 131072));
    endfunction

    task automatic add_item(logic [1:0] kind, int idx, int coef, logic [31:0] drv,
                            bit typed, out_word_t res);
        stim_row_t r;
        r = '{default: '0};
        r.word.kind = kind;
        r.word.node_index = 10'(idx);
        r.word.coefficient = 18'(coef);
        r.word.drive = drv;
        r.typed = typed;
        r.result = res;
        stim_table.push_back(r);
    endtask

    task automatic add_cfg(logic [2:0] idx, logic [31:0] v);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = v;
        stim_table.push_back(r);
    endtask

    // result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word", longint'(m_data.energy), 0);
            end else begin
                want = pending_results.pop_front();
                if (m_data.is_energy !== want.is_energy)
                    report_mismatch("is_energy", m_data.is_energy, want.is_energy);
                if (m_data.node_value !== want.node_value)
                    report_mismatch("node_value", m_data.node_value, want.node_value);
                if (m_data.energy !== want.energy)
                    report_mismatch("energy", m_data.energy, want.energy);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > RunLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side backpressure
    initial begin
        m_ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 22);
            end
        end
    end

    initial begin
        out_word_t none;
        out_word_t zero_read;
        out_word_t zero_energy;
        int items;
        none = '0;
        zero_read = '0;
        zero_energy = '0;
        zero_energy.is_energy = 1'b1;
        error_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        hold_go = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        for (int i = 0; i < MaxNodes; i++) begin
            disp_now[i] = 0;
            disp_old[i] = 0;
            node_coef[i] = 0;
        end
        cfg_scheme = SCH_A;
        cfg_left = BND_FIXED;
        cfg_right = BND_FIXED;
        cfg_lcour = 0;
        cfg_rcour = 0;
        cfg_count = MaxNodes;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        add_item(KIND_READ, 0, 0, 0, 1, zero_read);
        add_item(KIND_READ, 1023, 0, 0, 1, zero_read);
        add_item(2'd3, 7, 5, 32'h1234, 0, none);
        add_item(KIND_STEP, 0, 0, 0, 1, zero_energy);
        add_cfg(REG_COUNT, 4);
        add_cfg(REG_LEFT, 32'(BND_DRIVE));
        add_cfg(REG_RIGHT, 32'(BND_FREE));
        add_item(KIND_LOAD, 1, 131072, 0, 0, none);
        add_item(KIND_LOAD, 2, 262143, 0, 0, none);
        add_item(KIND_LOAD, 0, 65536, 0, 0, none);
        add_item(KIND_LOAD, 1023, 1, 0, 0, none);
        add_item(KIND_STEP, 0, 0, 32'h7FFF_FFFF, 0, none);
        add_item(KIND_STEP, 0, 0, 32'h8000_0000, 0, none);
        add_item(KIND_STEP, 0, 0, 32'h0001_0000, 0, none);
        add_item(KIND_READ, 0, 0, 0, 0, none);
        add_item(KIND_READ, 1, 0, 0, 0, none);
        add_item(KIND_READ, 3, 0, 0, 0, none);
        add_item(KIND_READ, 1023, 0, 0, 0, none);
        add_cfg(REG_SCHEME, 32'(SCH_B));
        add_item(KIND_STEP, 0, 0, 32'hFFFF_0000, 0, none);
        add_cfg(REG_SCHEME, 32'(SCH_C));
        add_item(KIND_STEP, 0, 0, 32'h0003_8000, 0, none);
        add_cfg(REG_SCHEME, 3);
        add_item(KIND_STEP, 0, 0, 32'h0000_0001, 0, none);
        add_cfg(REG_RIGHT, 32'(BND_OUT));
        add_cfg(REG_RCOUR, 131072);
        add_item(KIND_STEP, 0, 0, 32'h0002_0000, 0, none);
        add_cfg(REG_LEFT, 32'(BND_OUT));
        add_cfg(REG_LCOUR, 32'h3FFFF);
        add_item(KIND_STEP, 0, 0, 0, 0, none);
        add_cfg(REG_COUNT, 0);
        add_cfg(3'd6, 32'hFFFF_FFFF);
        add_cfg(3'd7, 1);
        add_item(KIND_STEP, 0, 0, 0, 0, none);
        add_item(KIND_READ, 2, 0, 0, 0, none);

        foreach (stim_table[k]) begin
            if (stim_table[k].is_cfg) begin
                drain_results();
                write_register(stim_table[k].reg_idx, stim_table[k].reg_val);
            end else begin
                send_word(stim_table[k].word, stim_table[k].typed, stim_table[k].result);
            end
        end

        items = 0;
        for (int ph = 0; items < 580; ph++) begin
            drain_results();
            calm = (ph == 1);
            write_register(REG_SCHEME, $urandom_range(0, 3));
            write_register(REG_LEFT, ($urandom_range(0, 2) == 0) ? $urandom_range(0, 3)
                                                                 : 32'(BND_DRIVE));
            write_register(REG_RIGHT, $urandom_range(0, 3));
            write_register(REG_LCOUR, courant_value());
            write_register(REG_RCOUR, courant_value());
            if (ph == 4) write_register(REG_COUNT, 1024);
            else if (ph == 7) write_register(REG_COUNT, 2047);
            else if (ph % 5 == 2) write_register(REG_COUNT, $urandom_range(0, 3));
            else write_register(REG_COUNT, $urandom_range(3, 24));
            if (ph == 3) hold_go = 1'b1;
            for (int j = 0; j < 40; j++) begin
                send_word(random_word(), 0, none);
                items++;
            end
        end

        drain_results();
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
